// File: hw/rtl/sbpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo bus packet transaction package
// Shared types and codes for the framer/checker front, queue and back end.
// ----------------------------------------------------------------------------
package sbpt_pkg;

  localparam int unsigned MaxPacket  = 512;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = 1;

  localparam logic [1:0] CMD_TX  = 2'd0;
  localparam logic [1:0] CMD_RX  = 2'd1;
  localparam logic [1:0] CMD_TMO = 2'd2;

  localparam logic [1:0] KIND_BUS    = 2'd0;
  localparam logic [1:0] KIND_PARAM  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CORRUPT = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  localparam logic [7:0] HDR_BYTE     = 8'hFF;
  localparam logic [7:0] BCAST_ADDR   = 8'd254;
  localparam logic [7:0] READ_INSTR   = 8'd2;
  localparam logic [8:0] REPLY_BASE   = 9'd6;
  localparam logic [8:0] LEN_OFFSET   = 9'd4;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_SEND = 3'b010,
    PH_RECV = 3'b100
  } phase_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] status;
    logic [7:0] err;
  } res_t;

  typedef struct packed {
    logic [1:0]     cnt;
    res_t [2:0]     slot;
  } rec_t;

endpackage

// File: hw/rtl/sbpt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo bus packet transaction front end
// Accepts requests, tracks framing and reply state, builds result records.
// ----------------------------------------------------------------------------
module sbpt_front #(
  parameter int unsigned MAX_PACKET = sbpt_pkg::MaxPacket
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      command_i,
  input  logic [7:0]      data_byte_i,
  input  logic            body_last_i,
  input  logic            full_i,
  output logic            push_o,
  output sbpt_pkg::rec_t  rec_o
);

  localparam int unsigned IdxW = $clog2(MAX_PACKET);
  localparam logic [IdxW-1:0] IdxMax = IdxW'(MAX_PACKET - 1);

  sbpt_pkg::phase_e phase_q, phase_d;
  logic [IdxW-1:0] body_index_q, body_index_d;
  logic [7:0] body_sum_q, body_sum_d;
  logic [7:0] target_id_q, target_id_d;
  logic [7:0] instr_q, instr_d;
  logic [7:0] read_count_q, read_count_d;
  logic [8:0] reply_expected_q, reply_expected_d;
  logic [8:0] reply_count_q, reply_count_d;
  logic [7:0] reply_sum_q, reply_sum_d;
  logic [7:0] reply_length_q, reply_length_d;
  logic       header_good_q, header_good_d;
  logic [7:0] reply_error_q, reply_error_d;

  logic            accept;
  logic            first;
  logic [IdxW-1:0] idx;
  logic [7:0]      sum_new;
  logic            body_end;
  logic            reply_done;
  logic            reply_ok;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    phase_d          = phase_q;
    body_index_d     = body_index_q;
    body_sum_d       = body_sum_q;
    target_id_d      = target_id_q;
    instr_d          = instr_q;
    read_count_d     = read_count_q;
    reply_expected_d = reply_expected_q;
    reply_count_d    = reply_count_q;
    reply_sum_d      = reply_sum_q;
    reply_length_d   = reply_length_q;
    header_good_d    = header_good_q;
    reply_error_d    = reply_error_q;
    push_o           = 1'b0;
    rec_o            = '0;

    first      = (phase_q == sbpt_pkg::PH_IDLE);
    idx        = first ? '0 : body_index_q;
    sum_new    = (first ? 8'd0 : body_sum_q) + data_byte_i;
    body_end   = body_last_i && (idx != '0);
    reply_done = ({1'b0, reply_count_q} + 10'd1) >= {1'b0, reply_expected_q};
    reply_ok   = header_good_q
              && (({1'b0, reply_length_q} + sbpt_pkg::LEN_OFFSET) == reply_expected_q)
              && (data_byte_i == ~reply_sum_q);

    if (accept) begin
      if (command_i == sbpt_pkg::CMD_TX && phase_q != sbpt_pkg::PH_RECV) begin
        push_o     = 1'b1;
        body_sum_d = sum_new;
        if (first) begin
          instr_d      = 8'd0;
          read_count_d = 8'd0;
          phase_d      = sbpt_pkg::PH_SEND;
        end
        if (idx == IdxW'(0)) target_id_d = data_byte_i;
        else if (idx == IdxW'(2)) instr_d = data_byte_i;
        else if (idx == IdxW'(4)) read_count_d = data_byte_i;

        if (first) begin
          rec_o.cnt          = 2'd3;
          rec_o.slot[0].kind = sbpt_pkg::KIND_BUS;
          rec_o.slot[0].data = sbpt_pkg::HDR_BYTE;
          rec_o.slot[1].kind = sbpt_pkg::KIND_BUS;
          rec_o.slot[1].data = sbpt_pkg::HDR_BYTE;
          rec_o.slot[2].kind = sbpt_pkg::KIND_BUS;
          rec_o.slot[2].data = data_byte_i;
        end else begin
          rec_o.cnt          = 2'd1;
          rec_o.slot[0].kind = sbpt_pkg::KIND_BUS;
          rec_o.slot[0].data = data_byte_i;
        end

        if (body_end) begin
          body_index_d       = '0;
          rec_o.cnt          = 2'd2;
          rec_o.slot[1].kind = sbpt_pkg::KIND_BUS;
          rec_o.slot[1].data = ~sum_new;
          if (target_id_q == sbpt_pkg::BCAST_ADDR) begin
            phase_d              = sbpt_pkg::PH_IDLE;
            rec_o.cnt            = 2'd3;
            rec_o.slot[2].kind   = sbpt_pkg::KIND_STATUS;
            rec_o.slot[2].status = sbpt_pkg::ST_OK;
          end else begin
            phase_d          = sbpt_pkg::PH_RECV;
            reply_expected_d = (instr_d == sbpt_pkg::READ_INSTR)
                             ? ({1'b0, read_count_d} + sbpt_pkg::REPLY_BASE)
                             : sbpt_pkg::REPLY_BASE;
            reply_count_d    = '0;
            reply_sum_d      = '0;
            reply_length_d   = '0;
            header_good_d    = 1'b1;
            reply_error_d    = '0;
          end
        end else if (idx < IdxMax) begin
          body_index_d = idx + IdxW'(1);
        end else begin
          body_index_d = idx;
        end
      end else if (command_i == sbpt_pkg::CMD_RX && phase_q == sbpt_pkg::PH_RECV) begin
        if (reply_done) begin
          push_o               = 1'b1;
          rec_o.cnt            = 2'd1;
          rec_o.slot[0].kind   = sbpt_pkg::KIND_STATUS;
          rec_o.slot[0].status = reply_ok ? sbpt_pkg::ST_OK : sbpt_pkg::ST_CORRUPT;
          rec_o.slot[0].err    = reply_error_q;
          phase_d              = sbpt_pkg::PH_IDLE;
          reply_count_d        = '0;
        end else begin
          if (reply_count_q < 9'd2) begin
            if (data_byte_i != sbpt_pkg::HDR_BYTE) header_good_d = 1'b0;
          end else begin
            reply_sum_d = reply_sum_q + data_byte_i;
            if (reply_count_q == 9'd3) reply_length_d = data_byte_i;
            else if (reply_count_q == 9'd4) reply_error_d = data_byte_i;
            else if (reply_count_q >= 9'd5) begin
              push_o             = 1'b1;
              rec_o.cnt          = 2'd1;
              rec_o.slot[0].kind = sbpt_pkg::KIND_PARAM;
              rec_o.slot[0].data = data_byte_i;
            end
          end
          reply_count_d = reply_count_q + 9'd1;
        end
      end else if (command_i == sbpt_pkg::CMD_TMO && phase_q == sbpt_pkg::PH_RECV) begin
        push_o               = 1'b1;
        rec_o.cnt            = 2'd1;
        rec_o.slot[0].kind   = sbpt_pkg::KIND_STATUS;
        rec_o.slot[0].status = sbpt_pkg::ST_TIMEOUT;
        rec_o.slot[0].err    = reply_error_q;
        phase_d              = sbpt_pkg::PH_IDLE;
        reply_count_d        = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= sbpt_pkg::PH_IDLE;
      body_index_q     <= '0;
      body_sum_q       <= '0;
      target_id_q      <= '0;
      instr_q          <= '0;
      read_count_q     <= '0;
      reply_expected_q <= '0;
      reply_count_q    <= '0;
      reply_sum_q      <= '0;
      reply_length_q   <= '0;
      header_good_q    <= 1'b1;
      reply_error_q    <= '0;
    end else begin
      phase_q          <= phase_d;
      body_index_q     <= body_index_d;
      body_sum_q       <= body_sum_d;
      target_id_q      <= target_id_d;
      instr_q          <= instr_d;
      read_count_q     <= read_count_d;
      reply_expected_q <= reply_expected_d;
      reply_count_q    <= reply_count_d;
      reply_sum_q      <= reply_sum_d;
      reply_length_q   <= reply_length_d;
      header_good_q    <= header_good_d;
      reply_error_q    <= reply_error_d;
    end
  end

  a_recv_expect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == sbpt_pkg::PH_RECV |-> reply_expected_q >= sbpt_pkg::REPLY_BASE)
    else $error("reply length below minimum while awaiting reply");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (rec_o.cnt != 2'd0 && accept))
    else $error("empty or unrequested record pushed");

endmodule

// File: hw/rtl/sbpt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo bus packet transaction record queue
// Short FIFO of result records between front end and back end.
// ----------------------------------------------------------------------------
module sbpt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sbpt_pkg::rec_t  rec_i,
  input  logic            pop_i,
  output sbpt_pkg::rec_t  head_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int unsigned CntW = $clog2(sbpt_pkg::QueueDepth + 1);

  sbpt_pkg::rec_t mem_q [sbpt_pkg::QueueDepth];
  logic [sbpt_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [sbpt_pkg::QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push;
  logic do_pop;

  assign full_o  = (cnt_q == CntW'(sbpt_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) wr_ptr_d = wr_ptr_q + sbpt_pkg::QPtrW'(1);
    if (do_pop)  rd_ptr_d = rd_ptr_q + sbpt_pkg::QPtrW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    else if (!do_push && do_pop) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

endmodule

// File: hw/rtl/sbpt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo bus packet transaction back end
// Serialises each queued record into single result items.
// ----------------------------------------------------------------------------
module sbpt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  sbpt_pkg::rec_t  head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      status_o,
  output logic [7:0]      device_error_o,
  output logic            last_o
);

  logic [1:0] idx_q, idx_d;
  sbpt_pkg::res_t cur;
  logic take;

  assign out_valid_o    = !empty_i;
  assign cur            = head_i.slot[idx_q];
  assign kind_o         = cur.kind;
  assign out_byte_o     = cur.data;
  assign status_o       = cur.status;
  assign device_error_o = cur.err;
  assign last_o         = (idx_q == head_i.cnt - 2'd1);
  assign take           = out_valid_o && out_ready_i;
  assign pop_o          = take && last_o;

  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = last_o ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (head_i.cnt != 2'd0 && idx_q < head_i.cnt))
    else $error("result index beyond record");

  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> idx_q == 2'd0)
    else $error("stale result index with empty queue");

endmodule

// File: hw/rtl/servo_bus_packet_transaction.sv
`timescale 1ns / 1ps
// Path: a request's results are registered in the record queue and shown from its head.
// Throughput: one request per cycle while the two-record queue has room.
// Output: one result per cycle while out_ready_i is high; records go out whole.
// The output serialiser sets the sustained rate: up to three results per request.
// Reset: asynchronous, active low; state returns to idle and the queue empties.
// ----------------------------------------------------------------------------
// Servo bus packet transaction
// Frames instruction packets and checks the servo reply.
// ----------------------------------------------------------------------------
module servo_bus_packet_transaction #(
  parameter int unsigned MAX_PACKET = sbpt_pkg::MaxPacket
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] command_i,
  input  logic [7:0] data_byte_i,
  input  logic       body_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic [1:0] status_o,
  output logic [7:0] device_error_o,
  output logic       last_o
);

  logic           push;
  logic           pop;
  logic           full;
  logic           empty;
  sbpt_pkg::rec_t rec;
  sbpt_pkg::rec_t head;

  sbpt_front #(
    .MAX_PACKET(MAX_PACKET)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .data_byte_i(data_byte_i),
    .body_last_i(body_last_i),
    .full_i     (full),
    .push_o     (push),
    .rec_o      (rec)
  );

  sbpt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (rec),
    .pop_i  (pop),
    .head_o (head),
    .full_o (full),
    .empty_o(empty)
  );

  sbpt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .out_byte_o    (out_byte_o),
    .status_o      (status_o),
    .device_error_o(device_error_o),
    .last_o        (last_o)
  );

endmodule

// File: tb/sbpt_exchange_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo bus exchange checker
// Watches the request and result channels, tracks packet framing and reply
// checking on its own, and compares every result against the oldest one due.
// ----------------------------------------------------------------------------
module sbpt_exchange_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [1:0] command_i,
  input  logic [7:0] data_byte_i,
  input  logic       body_last_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [1:0] kind_i,
  input  logic [7:0] out_byte_i,
  input  logic [1:0] status_i,
  input  logic [7:0] device_error_i,
  input  logic       last_i,
  output int         pending_o,
  output int         fail_count_o
);

  localparam logic [8:0] PosId         = 9'd0;
  localparam logic [8:0] PosInstr      = 9'd2;
  localparam logic [8:0] PosCount      = 9'd4;
  localparam logic [8:0] HeaderBytes   = 9'd2;
  localparam logic [8:0] ReplyPosLen   = 9'd3;
  localparam logic [8:0] ReplyPosErr   = 9'd4;
  localparam logic [8:0] ReplyPosParam = 9'd5;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] status;
    logic [7:0] err;
    logic       last;
  } bus_result_t;

  bus_result_t due_results[$];

  sbpt_pkg::phase_e phase_q;
  logic [8:0] body_idx;
  logic [7:0] body_sum;
  logic [7:0] tgt_id;
  logic [7:0] instr;
  logic [7:0] rd_cnt;
  logic [8:0] rep_exp;
  logic [8:0] rep_cnt;
  logic [7:0] rep_sum;
  logic [7:0] rep_len;
  logic       hdr_ok;
  logic [7:0] rep_err;

  function automatic bus_result_t mk_result(input logic [1:0] kind, input logic [7:0] data,
                                            input logic [1:0] status, input logic [7:0] err);
    bus_result_t r;
    r.kind   = kind;
    r.data   = data;
    r.status = status;
    r.err    = err;
    r.last   = 1'b0;
    return r;
  endfunction

  task automatic advance_exchange(input logic [1:0] cmd, input logic [7:0] b, input logic bl);
    bus_result_t batch[$];
    logic [8:0]  pos;
    logic        ok;
    if (cmd == sbpt_pkg::CMD_TX && phase_q != sbpt_pkg::PH_RECV) begin
      if (phase_q == sbpt_pkg::PH_IDLE) begin
        phase_q  = sbpt_pkg::PH_SEND;
        body_idx = '0;
        body_sum = '0;
        instr    = '0;
        rd_cnt   = '0;
        batch.push_back(mk_result(sbpt_pkg::KIND_BUS, sbpt_pkg::HDR_BYTE, sbpt_pkg::ST_OK,
                                  8'd0));
        batch.push_back(mk_result(sbpt_pkg::KIND_BUS, sbpt_pkg::HDR_BYTE, sbpt_pkg::ST_OK,
                                  8'd0));
      end
      case (body_idx)
        PosId:    tgt_id = b;
        PosInstr: instr  = b;
        PosCount: rd_cnt = b;
        default: ;
      endcase
      body_sum = body_sum + b;
      batch.push_back(mk_result(sbpt_pkg::KIND_BUS, b, sbpt_pkg::ST_OK, 8'd0));
      if (bl && body_idx != PosId) begin
        batch.push_back(mk_result(sbpt_pkg::KIND_BUS, ~body_sum, sbpt_pkg::ST_OK, 8'd0));
        body_idx = '0;
        if (tgt_id == sbpt_pkg::BCAST_ADDR) begin
          phase_q = sbpt_pkg::PH_IDLE;
          batch.push_back(mk_result(sbpt_pkg::KIND_STATUS, 8'd0, sbpt_pkg::ST_OK, 8'd0));
        end else begin
          phase_q = sbpt_pkg::PH_RECV;
          rep_exp = (instr == sbpt_pkg::READ_INSTR) ? {1'b0, rd_cnt} + sbpt_pkg::REPLY_BASE
                                                    : sbpt_pkg::REPLY_BASE;
          rep_cnt = '0;
          rep_sum = '0;
          rep_len = '0;
          hdr_ok  = 1'b1;
          rep_err = '0;
        end
      end else if (body_idx < sbpt_pkg::MaxPacket - 1) begin
        body_idx = body_idx + 9'd1;
      end
    end else if (cmd == sbpt_pkg::CMD_RX && phase_q == sbpt_pkg::PH_RECV) begin
      pos = rep_cnt;
      if (pos + 9'd1 >= rep_exp) begin
        ok = hdr_ok && ({1'b0, rep_len} + sbpt_pkg::LEN_OFFSET == rep_exp)
          && (b == ~rep_sum);
        batch.push_back(mk_result(sbpt_pkg::KIND_STATUS, 8'd0,
                                  ok ? sbpt_pkg::ST_OK : sbpt_pkg::ST_CORRUPT, rep_err));
        phase_q = sbpt_pkg::PH_IDLE;
        rep_cnt = '0;
      end else begin
        if (pos < HeaderBytes) begin
          if (b != sbpt_pkg::HDR_BYTE) hdr_ok = 1'b0;
        end else begin
          rep_sum = rep_sum + b;
          if (pos == ReplyPosLen) rep_len = b;
          else if (pos == ReplyPosErr) rep_err = b;
          else if (pos >= ReplyPosParam) begin
            batch.push_back(mk_result(sbpt_pkg::KIND_PARAM, b, sbpt_pkg::ST_OK, 8'd0));
          end
        end
        rep_cnt = pos + 9'd1;
      end
    end else if (cmd == sbpt_pkg::CMD_TMO && phase_q == sbpt_pkg::PH_RECV) begin
      batch.push_back(mk_result(sbpt_pkg::KIND_STATUS, 8'd0, sbpt_pkg::ST_TIMEOUT, rep_err));
      phase_q = sbpt_pkg::PH_IDLE;
      rep_cnt = '0;
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) due_results.push_back(batch[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    bus_result_t want;
    if (!rst_ni) begin
      due_results.delete();
      phase_q      = sbpt_pkg::PH_IDLE;
      body_idx     = '0;
      body_sum     = '0;
      tgt_id       = '0;
      instr        = '0;
      rd_cnt       = '0;
      rep_exp      = '0;
      rep_cnt      = '0;
      rep_sum      = '0;
      rep_len      = '0;
      hdr_ok       = 1'b1;
      rep_err      = '0;
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          $error("result with nothing due: kind %0d, out_byte %02h", kind_i, out_byte_i);
          fail_count_o++;
        end else begin
          want = due_results.pop_front();
          if (kind_i !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind_i);
            fail_count_o++;
          end
          if (out_byte_i !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_byte_i);
            fail_count_o++;
          end
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            fail_count_o++;
          end
          if (device_error_i !== want.err) begin
            $error("device_error: expected %02h, got %02h", want.err, device_error_i);
            fail_count_o++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) advance_exchange(command_i, data_byte_i, body_last_i);
      pending_o = due_results.size();
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo bus packet transaction testbench
// Sends instruction bodies, clean and damaged replies, timeouts and stray
// requests through the block under varied idling and back-pressure; the
// exchange checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned RandomItems = 220;
  localparam int unsigned PhaseItems  = RandomItems / 4;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned LongBody    = 24;
  localparam int unsigned DrainCycles = 20;
  localparam logic [1:0]  CMD_SPARE   = 2'd3;

  typedef enum int unsigned {
    REPLY_CLEAN,
    REPLY_HEADER,
    REPLY_LENGTH,
    REPLY_CHECKSUM,
    REPLY_TIMEOUT
  } reply_fault_e;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] command_i;
  logic [7:0] data_byte_i;
  logic       body_last_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [1:0] kind_o;
  logic [7:0] out_byte_o;
  logic [1:0] status_o;
  logic [7:0] device_error_o;
  logic       last_o;

  int          pending;
  int          fail_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned item_count;
  int unsigned hold_requests;

  servo_bus_packet_transaction u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .command_i,
    .data_byte_i,
    .body_last_i,
    .out_valid_o,
    .out_ready_i,
    .kind_o,
    .out_byte_o,
    .status_o,
    .device_error_o,
    .last_o
  );

  sbpt_exchange_checker u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i     (in_ready_o),
    .command_i,
    .data_byte_i,
    .body_last_i,
    .out_valid_i    (out_valid_o),
    .out_ready_i,
    .kind_i         (kind_o),
    .out_byte_i     (out_byte_o),
    .status_i       (status_o),
    .device_error_i (device_error_o),
    .last_i         (last_o),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : receiver
    int unsigned hold_left;
    int unsigned hold_served;
    hold_left   = 0;
    hold_served = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_request(input logic [1:0] cmd, input logic [7:0] b, input logic bl,
                              input bit counted);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    data_byte_i <= b;
    body_last_i <= bl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (counted) item_count++;
  endtask

  task automatic send_noise(input bit awaiting_reply);
    logic [1:0] cmd;
    if (awaiting_reply) begin
      cmd = $urandom_range(1) ? sbpt_pkg::CMD_TX : CMD_SPARE;
    end else begin
      case ($urandom_range(2))
        0: cmd = sbpt_pkg::CMD_RX;
        1: cmd = sbpt_pkg::CMD_TMO;
        default: cmd = CMD_SPARE;
      endcase
    end
    send_request(cmd, 8'($urandom), 1'($urandom), 1'b0);
  endtask

  task automatic send_body(input logic [7:0] body[$], input bit first_last, input bit noisy);
    foreach (body[i]) begin
      if (noisy && $urandom_range(9) == 0) send_noise(1'b0);
      send_request(sbpt_pkg::CMD_TX, body[i],
                   (i == body.size() - 1) || (i == 0 && first_last), 1'b1);
    end
  endtask

  function automatic int unsigned reply_total(input logic [7:0] body[$]);
    logic [7:0] op;
    logic [7:0] cnt;
    op  = (body.size() > 2) ? body[2] : 8'd0;
    cnt = (body.size() > 4) ? body[4] : 8'd0;
    return (op == sbpt_pkg::READ_INSTR) ? int'(cnt) + int'(sbpt_pkg::REPLY_BASE)
                                        : int'(sbpt_pkg::REPLY_BASE);
  endfunction

  task automatic send_reply(input logic [7:0] id, input int unsigned total,
                            input reply_fault_e fault, input bit noisy);
    logic [7:0]  reply[$];
    logic [7:0]  sum;
    int unsigned cut;
    reply = {sbpt_pkg::HDR_BYTE, sbpt_pkg::HDR_BYTE, id,
             8'(total - int'(sbpt_pkg::LEN_OFFSET)), 8'($urandom)};
    for (int i = 0; i < int'(total) - int'(sbpt_pkg::REPLY_BASE); i++) begin
      reply.push_back(8'($urandom));
    end
    if (fault == REPLY_HEADER) reply[$urandom_range(1)] ^= 8'($urandom_range(1, 255));
    if (fault == REPLY_LENGTH) reply[3] ^= 8'($urandom_range(1, 255));
    sum = 8'd0;
    for (int i = 2; i < reply.size(); i++) sum += reply[i];
    sum = ~sum;
    if (fault == REPLY_CHECKSUM) sum ^= 8'($urandom_range(1, 255));
    reply.push_back(sum);
    cut = (fault == REPLY_TIMEOUT) ? $urandom_range(total - 1) : total;
    for (int i = 0; i < cut; i++) begin
      if (noisy && $urandom_range(9) == 0) send_noise(1'b1);
      send_request(sbpt_pkg::CMD_RX, reply[i], 1'($urandom), 1'b1);
    end
    if (fault == REPLY_TIMEOUT) begin
      send_request(sbpt_pkg::CMD_TMO, 8'($urandom), 1'($urandom), 1'b1);
    end
  endtask

  task automatic run_exchange();
    logic [7:0]   body[$];
    int unsigned  len;
    int unsigned  pick;
    reply_fault_e fault;
    len = $urandom_range(2, 8);
    for (int i = 0; i < len; i++) body.push_back(8'($urandom));
    if ($urandom_range(6) == 0) body[0] = sbpt_pkg::BCAST_ADDR;
    if (len > 2 && $urandom_range(1)) body[2] = sbpt_pkg::READ_INSTR;
    if (len > 4) body[4] = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(6));
    send_body(body, 1'($urandom), 1'b1);
    if (body[0] != sbpt_pkg::BCAST_ADDR) begin
      pick  = $urandom_range(9);
      fault = (pick < 6) ? REPLY_CLEAN : reply_fault_e'(pick - 5);
      send_reply(body[0], reply_total(body), fault, 1'b1);
    end
  endtask

  initial begin : stimulus
    logic [7:0] body[$];
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    command_i      = sbpt_pkg::CMD_TX;
    data_byte_i    = 8'd0;
    body_last_i    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    item_count     = 0;
    hold_requests  = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(sbpt_pkg::CMD_RX, 8'hFF, 1'b1, 1'b0);
    send_request(sbpt_pkg::CMD_TMO, 8'h00, 1'b0, 1'b0);
    send_request(CMD_SPARE, 8'hA5, 1'b1, 1'b0);

    body = {sbpt_pkg::BCAST_ADDR, 8'h02, 8'h01};
    send_body(body, 1'b1, 1'b0);

    body = {8'h01, 8'h04, sbpt_pkg::READ_INSTR, 8'h24, 8'h02};
    send_body(body, 1'b0, 1'b0);
    send_request(sbpt_pkg::CMD_TX, 8'hFF, 1'b1, 1'b0);
    send_request(CMD_SPARE, 8'h00, 1'b0, 1'b0);
    send_reply(8'h01, reply_total(body), REPLY_CLEAN, 1'b0);

    body = {8'hFF, 8'h00};
    send_body(body, 1'b0, 1'b0);
    send_reply(8'hFF, reply_total(body), REPLY_TIMEOUT, 1'b0);

    body.delete();
    for (int i = 0; i < LongBody; i++) body.push_back(8'($urandom));
    body[0] = 8'($urandom_range(253));
    body[2] = sbpt_pkg::READ_INSTR;
    body[4] = 8'd3;
    send_body(body, 1'b0, 1'b0);
    send_reply(body[0], reply_total(body), REPLY_CLEAN, 1'b0);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_requests++;
        end
        1: begin
          send_idle_pct  = 80;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 80;
        end
        default: begin
          send_idle_pct  = 35;
          recv_stall_pct = 35;
        end
      endcase
      item_count = 0;
      while (item_count < PhaseItems) run_exchange();
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/sbpt_pkg.sv
hw/rtl/sbpt_front.sv
hw/rtl/sbpt_queue.sv
hw/rtl/sbpt_back.sv
hw/rtl/servo_bus_packet_transaction.sv
tb/sbpt_exchange_checker.sv
tb/tb.sv
